/* src/ipdm_pkg.sv */
// ----------------------------------------------------------------------------
// ipdm_pkg
// Shared types and constants for the integer power / divide / modulo unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdm_pkg;

	// default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// multiplier slice width; wider operands are multiplied in slices
	localparam int MUL_CHUNK = 32;

	// slice index width, enough for operands up to two slices
	localparam int MUL_IDX_W = 1;

	// operation codes
	typedef enum logic [1:0] {
		KIND_POW = 2'd0,
		KIND_DIV = 2'd1,
		KIND_MOD = 2'd2
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POW,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic                 load;
		logic                 pow_step;
		logic                 mul_first;
		logic                 mul_last;
		logic [MUL_IDX_W-1:0] mul_i;
		logic [MUL_IDX_W-1:0] mul_j;
		logic                 div_step;
		logic                 out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic start_pow;
		logic start_div;
		logic exp_zero;
	} sts_t;

endpackage

`default_nettype wire

/* src/ipdm_ctrl.sv */
// ----------------------------------------------------------------------------
// ipdm_ctrl
// Sequencer: walks the exponent bits for power, the quotient bits for divide
// and modulo, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdm_ctrl #(
	parameter int DATA_WIDTH = ipdm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire ipdm_pkg::sts_t sts,
	output ipdm_pkg::cmd_t     cmd
);
	import ipdm_pkg::*;

	localparam int NUM_CHUNK = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int CNT_W     = $clog2(DATA_WIDTH);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [MUL_IDX_W-1:0] mi_q, mj_q;
	logic                 out_valid_q;
	logic                 pair_end;
	logic                 mul_last;
	logic                 div_last;

	// slice pair bookkeeping for the wrapped multiply
	assign pair_end = ({1'b0, mi_q} + {1'b0, mj_q}) == (MUL_IDX_W + 1)'(NUM_CHUNK - 1);
	assign mul_last = pair_end && (mi_q == MUL_IDX_W'(NUM_CHUNK - 1));
	assign div_last = cnt_q == CNT_W'(DATA_WIDTH - 1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.start_pow) begin
						state_d = ST_POW;
					end else if (sts.start_div) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_POW: begin
				if (sts.exp_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.pow_step  = 1'b1;
					cmd.mul_first = (mi_q == '0) && (mj_q == '0);
					cmd.mul_last  = mul_last;
					cmd.mul_i     = mi_q;
					cmd.mul_j     = mj_q;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// divide step counter and multiply slice indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mi_q  <= '0;
			mj_q  <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load || (cmd.pow_step && mul_last)) begin
				mi_q <= '0;
				mj_q <= '0;
			end else if (cmd.pow_step) begin
				if (pair_end) begin
					mi_q <= mi_q + MUL_IDX_W'(1);
					mj_q <= '0;
				end else begin
					mj_q <= mj_q + MUL_IDX_W'(1);
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* src/ipdm_dpath.sv */
// ----------------------------------------------------------------------------
// ipdm_dpath
// Datapath: square-and-multiply registers with sliced multipliers, a
// restoring divider one quotient bit per step, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdm_dpath #(
	parameter int DATA_WIDTH = ipdm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [DATA_WIDTH-1:0] operand_a,
	input  wire logic signed [DATA_WIDTH-1:0] operand_b,
	input  wire ipdm_pkg::cmd_t               cmd,
	output ipdm_pkg::sts_t                    sts,
	output logic signed [DATA_WIDTH-1:0]      value,
	output logic                              status
);
	import ipdm_pkg::*;

	localparam int NUM_CHUNK = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PAD_W     = NUM_CHUNK * MUL_CHUNK;
	localparam int WIDE_W    = PAD_W + MUL_CHUNK;
	localparam int SH_W      = $clog2(WIDE_W);

	kind_t                 kind_in;
	logic [DATA_WIDTH-1:0] a_u, b_u, a_abs, b_abs;
	logic                  a_neg, b_neg;

	kind_t                 kind_q;
	logic                  qneg_q, aneg_q, bzero_q;
	logic [DATA_WIDTH-1:0] base_q, acc_q, pa_q, pb_q;
	logic [DATA_WIDTH-2:0] exp_q;
	logic [DATA_WIDTH-1:0] rem_q, quo_q, div_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic                  status_q;

	logic [PAD_W-1:0]       acc_pad, base_pad;
	logic [MUL_CHUNK-1:0]   acc_i, base_i, base_j;
	logic [2*MUL_CHUNK-1:0] pa_prod, pb_prod;
	logic [SH_W-1:0]        sh;
	logic [WIDE_W-1:0]      pa_wide, pb_wide;
	logic [DATA_WIDTH-1:0]  pa_sum, pb_sum;

	logic [DATA_WIDTH:0]   rem_shift, diff;
	logic                  fit;

	logic [DATA_WIDTH-1:0] res_value;
	logic                  res_status;

	// operand decode
	assign kind_in = kind_t'(kind);
	assign a_u     = $unsigned(operand_a);
	assign b_u     = $unsigned(operand_b);
	assign a_neg   = a_u[DATA_WIDTH-1];
	assign b_neg   = b_u[DATA_WIDTH-1];
	assign a_abs   = a_neg ? (~a_u + DATA_WIDTH'(1)) : a_u;
	assign b_abs   = b_neg ? (~b_u + DATA_WIDTH'(1)) : b_u;

	// status to the controller
	assign sts.start_pow = kind_in == KIND_POW;
	assign sts.start_div = ((kind_in == KIND_DIV) || (kind_in == KIND_MOD)) && (b_u != '0);
	assign sts.exp_zero  = exp_q == '0;

	// one slice pair of acc*base and base*base, accumulated over the pairs
	assign acc_pad  = PAD_W'(acc_q);
	assign base_pad = PAD_W'(base_q);
	assign acc_i    = acc_pad[cmd.mul_i * MUL_CHUNK +: MUL_CHUNK];
	assign base_i   = base_pad[cmd.mul_i * MUL_CHUNK +: MUL_CHUNK];
	assign base_j   = base_pad[cmd.mul_j * MUL_CHUNK +: MUL_CHUNK];
	assign pa_prod  = acc_i * base_j;
	assign pb_prod  = base_i * base_j;
	assign sh       = SH_W'({1'b0, cmd.mul_i} + {1'b0, cmd.mul_j}) * SH_W'(MUL_CHUNK);
	assign pa_wide  = WIDE_W'(pa_prod) << sh;
	assign pb_wide  = WIDE_W'(pb_prod) << sh;
	assign pa_sum   = (cmd.mul_first ? '0 : pa_q) + pa_wide[DATA_WIDTH-1:0];
	assign pb_sum   = (cmd.mul_first ? '0 : pb_q) + pb_wide[DATA_WIDTH-1:0];

	// restoring divide step
	assign rem_shift = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff      = rem_shift - {1'b0, div_q};
	assign fit       = !diff[DATA_WIDTH];

	// power and divide registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_in;
			qneg_q  <= a_neg ^ b_neg;
			aneg_q  <= a_neg;
			bzero_q <= b_u == '0;
			base_q  <= a_u;
			acc_q   <= b_neg ? '0 : DATA_WIDTH'(1);
			exp_q   <= b_neg ? '0 : b_u[DATA_WIDTH-2:0];
			rem_q   <= '0;
			quo_q   <= a_abs;
			div_q   <= b_abs;
		end else if (cmd.pow_step) begin
			if (cmd.mul_last) begin
				if (exp_q[0]) begin
					acc_q <= pa_sum;
				end
				base_q <= pb_sum;
				exp_q  <= exp_q >> 1;
			end else begin
				pa_q <= pa_sum;
				pb_q <= pb_sum;
			end
		end else if (cmd.div_step) begin
			rem_q <= fit ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], fit};
		end
	end

	// result select
	always_comb begin
		res_value  = '0;
		res_status = 1'b0;
		case (kind_q)
			KIND_POW: begin
				res_value = acc_q;
			end
			KIND_DIV: begin
				if (bzero_q) begin
					res_status = 1'b1;
				end else begin
					res_value = qneg_q ? (~quo_q + DATA_WIDTH'(1)) : quo_q;
				end
			end
			KIND_MOD: begin
				if (bzero_q) begin
					res_status = 1'b1;
				end else begin
					res_value = aneg_q ? (~rem_q + DATA_WIDTH'(1)) : rem_q;
				end
			end
			default: begin
				res_value  = '0;
				res_status = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign value  = $signed(value_q);
	assign status = status_q;

endmodule

`default_nettype wire

/* src/int_power_divide_modulo_unit_core.sv */
// ----------------------------------------------------------------------------
// int_power_divide_modulo_unit_core
// Integer power, truncating divide and modulo on signed operands, one item
// at a time.
// ----------------------------------------------------------------------------
// Power: after the transfer in, the square-and-multiply loop takes one step per
//   exponent bit (no steps for a negative exponent); each step walks the slice
//   pairs, 1 slice pair up to 32 bits, 3 pairs above.
// Divide/modulo: one quotient bit per cycle.
// Zero divisor or unused code: straight to the result. Next item taken once the result is
//   in the output register. Reset clears controller state and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module int_power_divide_modulo_unit_core #(
	parameter int DATA_WIDTH = ipdm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [DATA_WIDTH-1:0] operand_a,
	input  wire logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      value,
	output logic                              status
);
	import ipdm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ipdm_ctrl #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	ipdm_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.status    (status)
	);

	// a divide-by-zero result carries a zero value
	a_dbz_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (value == '0))
		else $error("divide by zero result with nonzero value");

	// a new result never overwrites one still waiting to be taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// operands are captured only on an input transfer
	a_load_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && !in_stall))
		else $error("operand capture without input transfer");

	// output valid rises only after a result load
	a_valid_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("output valid without result load");

endmodule

`default_nettype wire
